FILE: hdl/referee_frame_parser_defines.svh
// Assertion macros used by the referee frame parser checker.
`ifndef REFEREE_FRAME_PARSER_DEFINES_SVH
`define REFEREE_FRAME_PARSER_DEFINES_SVH

// Clocked assertion, idle while reset is asserted.
`define RFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rfp_pkg.sv
// Types, constants and CRC step functions of the referee frame parser.
package rfp_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [7:0]  SOF_BYTE   = 8'hA5;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    localparam logic [15:0] CMD_ROBOT_STATUS = 16'h0201;
    localparam logic [15:0] CMD_POWER        = 16'h0202;
    localparam logic [15:0] LEN_ROBOT_STATUS = 16'd13;
    localparam logic [15:0] LEN_POWER        = 16'd14;
    localparam int          FRAME_OVERHEAD   = 9;
    localparam logic [15:0] TIMEOUT_DEF      = 16'd100;

    // Byte offsets inside a frame
    localparam int OFF_LEN_LO   = 1;
    localparam int OFF_LEN_HI   = 2;
    localparam int OFF_CRC8     = 4;
    localparam int OFF_CMD_LO   = 5;
    localparam int OFF_CMD_HI   = 6;
    localparam int OFF_ROBOT_ID = 7;
    localparam int OFF_ENERGY   = 15;
    localparam int OFF_POWER    = 17;
    localparam int OFF_FLAGS    = 19;
    localparam int HDR_CRC_LAST = 3;

    // Event codes
    localparam logic [2:0] EV_ROBOT_STATUS = 3'd0;
    localparam logic [2:0] EV_POWER        = 3'd1;
    localparam logic [2:0] EV_UNKNOWN_CMD  = 3'd2;
    localparam logic [2:0] EV_LENGTH       = 3'd3;
    localparam logic [2:0] EV_CRC8         = 3'd4;
    localparam logic [2:0] EV_CRC16        = 3'd5;
    localparam logic [2:0] EV_OVERSIZE     = 3'd6;
    localparam logic [2:0] EV_TIMEOUT      = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROTO_OK = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T0, ST_T1, ST_START, ST_B0, ST_C8, ST_C8CMP, ST_N1, ST_N2,
        ST_C16, ST_K1, ST_K2, ST_M5, ST_M6, ST_R7, ST_R17, ST_R18, ST_R19,
        ST_E15, ST_E16, ST_EMIT, ST_DROP, ST_FINISH
    } rfp_state_t;

    typedef struct packed {
        logic [7:0]  robot_id;
        logic [2:0]  flags;
        logic [15:0] power_limit;
        logic [15:0] energy;
        logic [31:0] stamp;
        logic [31:0] seq;
    } rfp_snap_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] cmd;
        rfp_snap_t   snap;
    } rfp_event_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic wide;
    } rfp_crc_ctl_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        r = c ^ d;
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/rfp_buffer.sv
// Circular byte and timestamp buffer with one write and one registered read port.
module rfp_buffer #(
    parameter int DEPTH = rfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] head,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_off,
    input  logic [7:0]               wr_byte,
    input  logic [31:0]              wr_time,
    input  logic [$clog2(DEPTH)-1:0] rd_off,
    output logic [7:0]               rd_byte,
    output logic [31:0]              rd_time
);
    localparam int PW = $clog2(DEPTH);

    logic [7:0]    byte_mem [DEPTH];
    logic [31:0]   time_mem [DEPTH];
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic [PW:0]   wr_sum;
    logic [PW:0]   rd_sum;

    // Wrap head + offset; both are below DEPTH
    always_comb
    begin
        wr_sum = {1'b0, head} + {1'b0, wr_off};
        rd_sum = {1'b0, head} + {1'b0, rd_off};
        if (wr_sum >= (PW+1)'(DEPTH))
        begin
            wr_sum = wr_sum - (PW+1)'(DEPTH);
        end
        if (rd_sum >= (PW+1)'(DEPTH))
        begin
            rd_sum = rd_sum - (PW+1)'(DEPTH);
        end
        wr_addr = wr_sum[PW-1:0];
        rd_addr = rd_sum[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_mem[wr_addr] <= wr_byte;
            time_mem[wr_addr] <= wr_time;
        end
        rd_byte <= byte_mem[rd_addr];
        rd_time <= time_mem[rd_addr];
    end

endmodule

FILE: hdl/rfp_crc.sv
// Shared CRC-8 / CRC-16 accumulator, one byte per cycle while step is set.
module rfp_crc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rfp_pkg::rfp_crc_ctl_t ctl,
    input  logic [7:0]            data,
    output logic [15:0]           crc
);
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.clear)
        begin
            crc_next = ctl.wide ? rfp_pkg::CRC16_INIT : {8'h00, rfp_pkg::CRC8_INIT};
        end
        else if (ctl.step)
        begin
            crc_next = ctl.wide ? rfp_pkg::crc16_byte(crc_reg, data)
                                : {8'h00, rfp_pkg::crc8_byte(crc_reg[7:0], data)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

FILE: hdl/rfp_event_out.sv
// Holds one event back until the next one or the end of the request marks it last.
module rfp_event_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                flush,
    input  rfp_pkg::rfp_event_t ev,
    output logic                stall,
    output logic                out_valid,
    input  logic                out_ready,
    output rfp_pkg::rfp_event_t out_ev,
    output logic                out_last
);
    logic                pend_valid_reg;
    logic                pend_valid_next;
    rfp_pkg::rfp_event_t pend_reg;
    rfp_pkg::rfp_event_t pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rfp_pkg::rfp_event_t out_ev_reg;
    rfp_pkg::rfp_event_t out_ev_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic                slot_free;

    always_comb
    begin
        slot_free       = !out_valid_reg || out_ready;
        stall           = pend_valid_reg && !slot_free;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_ev_next     = out_ev_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (!stall && (push || flush))
        begin
            // Move the held event out; it is last only on flush
            if (pend_valid_reg)
            begin
                out_ev_next    = pend_reg;
                out_last_next  = flush;
                out_valid_next = 1'b1;
            end
            pend_valid_next = push;
            if (push)
            begin
                pend_next = ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            pend_reg       <= '0;
            out_ev_reg     <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            pend_reg       <= pend_next;
            out_ev_reg     <= out_ev_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hdl/referee_frame_parser.sv
// Referee serial frame parser: a request with op 1 appends one byte (with its
// millisecond stamp) to a circular buffer of BUFFER_BYTES entries and rescans
// it, unless the buffer is full; op 0 checks the oldest partial frame against
// the configured timeout. A single sequencer walks the buffer through one read
// port, feeding one shared CRC unit one byte per cycle; every drop restarts the
// scan. Events leave through a one-deep hold stage and an output register, and
// a request ends only once its last event has moved to the output register;
// in_ready is high only between requests. No clearing pass after reset.
module referee_frame_parser #(
    parameter int BUFFER_BYTES = rfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic [31:0] now_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [15:0] command_id,
    output logic [7:0]  robot_id,
    output logic        gimbal_on,
    output logic        chassis_on,
    output logic        shooter_on,
    output logic [15:0] power_limit_w,
    output logic [15:0] buffer_energy_j,
    output logic [31:0] stamp_ms,
    output logic [31:0] message_seq,
    output logic        last
);
    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    rfp_pkg::rfp_state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] drop_n_reg, drop_n_next;
    logic [7:0]    lo_reg, lo_next;
    logic [15:0]   word_reg, word_next;
    logic [7:0]    robot_tmp_reg, robot_tmp_next;
    logic [15:0]   cmd_reg, cmd_next;
    logic [31:0]   stamp_tmp_reg, stamp_tmp_next;
    logic [31:0]   now_reg, now_next;
    logic [2:0]    kind_reg, kind_next;
    logic [15:0]   ev_cmd_reg, ev_cmd_next;
    logic          dec_reg, dec_next;
    logic          tmo_reg, tmo_next;
    logic [31:0]   fs_reg, fs_next;
    logic          fs_head_reg, fs_head_next;
    logic          proto_ok_reg, proto_ok_next;
    logic [15:0]   timeout_reg, timeout_next;
    rfp_pkg::rfp_snap_t snap_reg, snap_next;

    logic [PW-1:0] rd_off;
    logic          wr_en;
    logic [7:0]    rd_byte;
    logic [31:0]   rd_time;
    logic [15:0]   crc;
    rfp_pkg::rfp_crc_ctl_t crc_ctl;
    logic          ev_push;
    logic          ev_flush;
    logic          ev_stall;
    rfp_pkg::rfp_event_t ev, out_ev;

    logic [16:0]   frame_total;
    logic [31:0]   fs_eff;
    logic [CW:0]   head_sum;
    logic [15:0]   rd_word;

    rfp_buffer #(.DEPTH(BUFFER_BYTES)) u_buffer (
        .clk     (clk),
        .head    (head_reg),
        .wr_en   (wr_en),
        .wr_off  (fill_reg[PW-1:0]),
        .wr_byte (data_byte),
        .wr_time (now_ms),
        .rd_off  (rd_off),
        .rd_byte (rd_byte),
        .rd_time (rd_time)
    );

    rfp_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (rd_byte),
        .crc   (crc)
    );

    rfp_event_out u_event_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .flush     (ev_flush),
        .ev        (ev),
        .stall     (ev_stall),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_ev    (out_ev),
        .out_last  (last)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == rfp_pkg::ST_IDLE);

    always_comb
    begin
        ev.kind = kind_reg;
        ev.cmd  = ev_cmd_reg;
        ev.snap = snap_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        drop_n_next    = drop_n_reg;
        lo_next        = lo_reg;
        word_next      = word_reg;
        robot_tmp_next = robot_tmp_reg;
        cmd_next       = cmd_reg;
        stamp_tmp_next = stamp_tmp_reg;
        now_next       = now_reg;
        kind_next      = kind_reg;
        ev_cmd_next    = ev_cmd_reg;
        dec_next       = dec_reg;
        tmo_next       = tmo_reg;
        fs_next        = fs_reg;
        fs_head_next   = fs_head_reg;
        proto_ok_next  = proto_ok_reg;
        timeout_next   = timeout_reg;
        snap_next      = snap_reg;
        rd_off         = '0;
        wr_en          = 1'b0;
        crc_ctl        = '0;
        ev_push        = 1'b0;
        ev_flush       = 1'b0;
        rd_word        = {rd_byte, lo_reg};
        frame_total    = {1'b0, rd_word} + 17'(rfp_pkg::FRAME_OVERHEAD);
        fs_eff         = fs_head_reg ? rd_time : fs_reg;
        head_sum       = {1'b0, {(CW-PW){1'b0}}, head_reg} + {1'b0, drop_n_reg};
        if (head_sum >= (CW+1)'(BUFFER_BYTES))
        begin
            head_sum = head_sum - (CW+1)'(BUFFER_BYTES);
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                rfp_pkg::CFG_PROTO_OK: proto_ok_next = cfg_data[0];
                rfp_pkg::CFG_TIMEOUT:  timeout_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            rfp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next = now_ms;
                    tmo_next = 1'b0;
                    if (!op)
                    begin
                        state_next = (fill_reg == '0) ? rfp_pkg::ST_FINISH : rfp_pkg::ST_T0;
                    end
                    else if (fill_reg < CW'(BUFFER_BYTES))
                    begin
                        wr_en = 1'b1;
                        if (fill_reg == '0)
                        begin
                            fs_next      = now_ms;
                            fs_head_next = 1'b0;
                        end
                        fill_next  = fill_reg + 1'b1;
                        state_next = rfp_pkg::ST_START;
                    end
                    else
                    begin
                        state_next = rfp_pkg::ST_FINISH;
                    end
                end
            end
            rfp_pkg::ST_T0:
            begin
                state_next = rfp_pkg::ST_T1;
            end
            rfp_pkg::ST_T1:
            begin
                if ((now_reg < fs_eff) || ((now_reg - fs_eff) > {16'h0000, timeout_reg}))
                begin
                    kind_next   = rfp_pkg::EV_TIMEOUT;
                    ev_cmd_next = '0;
                    drop_n_next = CW'(1);
                    dec_next    = 1'b0;
                    tmo_next    = 1'b1;
                    state_next  = rfp_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rfp_pkg::ST_FINISH;
                end
            end
            rfp_pkg::ST_START:
            begin
                state_next = (fill_reg == '0) ? rfp_pkg::ST_FINISH : rfp_pkg::ST_B0;
            end
            rfp_pkg::ST_B0:
            begin
                drop_n_next = CW'(1);
                dec_next    = 1'b0;
                if (rd_byte != rfp_pkg::SOF_BYTE)
                begin
                    // Drop silently
                    state_next = rfp_pkg::ST_DROP;
                end
                else if (fill_reg < CW'(5))
                begin
                    state_next = rfp_pkg::ST_FINISH;
                end
                else
                begin
                    crc_ctl.clear = 1'b1;
                    idx_next      = '0;
                    state_next    = rfp_pkg::ST_C8;
                end
            end
            rfp_pkg::ST_C8:
            begin
                crc_ctl.step = 1'b1;
                rd_off       = idx_reg + 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == PW'(rfp_pkg::HDR_CRC_LAST))
                begin
                    state_next = rfp_pkg::ST_C8CMP;
                end
            end
            rfp_pkg::ST_C8CMP:
            begin
                if (crc[7:0] != rd_byte)
                begin
                    kind_next   = rfp_pkg::EV_CRC8;
                    ev_cmd_next = '0;
                    state_next  = rfp_pkg::ST_EMIT;
                end
                else
                begin
                    rd_off     = PW'(rfp_pkg::OFF_LEN_LO);
                    state_next = rfp_pkg::ST_N1;
                end
            end
            rfp_pkg::ST_N1:
            begin
                lo_next    = rd_byte;
                rd_off     = PW'(rfp_pkg::OFF_LEN_HI);
                state_next = rfp_pkg::ST_N2;
            end
            rfp_pkg::ST_N2:
            begin
                if (frame_total > 17'(BUFFER_BYTES))
                begin
                    kind_next   = rfp_pkg::EV_OVERSIZE;
                    ev_cmd_next = '0;
                    state_next  = rfp_pkg::ST_EMIT;
                end
                else if ({{(17-CW){1'b0}}, fill_reg} < frame_total)
                begin
                    state_next = rfp_pkg::ST_FINISH;
                end
                else
                begin
                    total_next    = frame_total[CW-1:0];
                    crc_ctl.clear = 1'b1;
                    crc_ctl.wide  = 1'b1;
                    idx_next      = '0;
                    state_next    = rfp_pkg::ST_C16;
                end
            end
            rfp_pkg::ST_C16:
            begin
                crc_ctl.step = 1'b1;
                crc_ctl.wide = 1'b1;
                rd_off       = idx_reg + 1'b1;
                idx_next     = idx_reg + 1'b1;
                if ({{(CW-PW){1'b0}}, idx_reg} == total_reg - CW'(3))
                begin
                    state_next = rfp_pkg::ST_K1;
                end
            end
            rfp_pkg::ST_K1:
            begin
                lo_next    = rd_byte;
                rd_off     = PW'(total_reg - CW'(1));
                state_next = rfp_pkg::ST_K2;
            end
            rfp_pkg::ST_K2:
            begin
                if (crc != rd_word)
                begin
                    kind_next   = rfp_pkg::EV_CRC16;
                    ev_cmd_next = '0;
                    state_next  = rfp_pkg::ST_EMIT;
                end
                else
                begin
                    stamp_tmp_next = rd_time;
                    rd_off         = PW'(rfp_pkg::OFF_CMD_LO);
                    state_next     = rfp_pkg::ST_M5;
                end
            end
            rfp_pkg::ST_M5:
            begin
                lo_next    = rd_byte;
                rd_off     = PW'(rfp_pkg::OFF_CMD_HI);
                state_next = rfp_pkg::ST_M6;
            end
            rfp_pkg::ST_M6:
            begin
                cmd_next    = rd_word;
                ev_cmd_next = rd_word;
                drop_n_next = total_reg;
                dec_next    = 1'b1;
                state_next  = rfp_pkg::ST_EMIT;
                if (!proto_ok_reg || ((rd_word != rfp_pkg::CMD_ROBOT_STATUS)
                                      && (rd_word != rfp_pkg::CMD_POWER)))
                begin
                    kind_next = rfp_pkg::EV_UNKNOWN_CMD;
                end
                else if (((rd_word == rfp_pkg::CMD_ROBOT_STATUS) && (total_reg !=
                          CW'(rfp_pkg::LEN_ROBOT_STATUS + 16'(rfp_pkg::FRAME_OVERHEAD))))
                      || ((rd_word == rfp_pkg::CMD_POWER) && (total_reg !=
                          CW'(rfp_pkg::LEN_POWER + 16'(rfp_pkg::FRAME_OVERHEAD)))))
                begin
                    kind_next = rfp_pkg::EV_LENGTH;
                end
                else if (rd_word == rfp_pkg::CMD_ROBOT_STATUS)
                begin
                    rd_off     = PW'(rfp_pkg::OFF_ROBOT_ID);
                    state_next = rfp_pkg::ST_R7;
                end
                else
                begin
                    rd_off     = PW'(rfp_pkg::OFF_ENERGY);
                    state_next = rfp_pkg::ST_E15;
                end
            end
            rfp_pkg::ST_R7:
            begin
                robot_tmp_next = rd_byte;
                rd_off         = PW'(rfp_pkg::OFF_POWER);
                state_next     = rfp_pkg::ST_R17;
            end
            rfp_pkg::ST_R17:
            begin
                lo_next    = rd_byte;
                rd_off     = PW'(rfp_pkg::OFF_POWER + 1);
                state_next = rfp_pkg::ST_R18;
            end
            rfp_pkg::ST_R18:
            begin
                word_next  = rd_word;
                rd_off     = PW'(rfp_pkg::OFF_FLAGS);
                state_next = rfp_pkg::ST_R19;
            end
            rfp_pkg::ST_R19:
            begin
                snap_next.robot_id    = robot_tmp_reg;
                snap_next.flags       = rd_byte[2:0];
                snap_next.power_limit = word_reg;
                snap_next.stamp       = stamp_tmp_reg;
                snap_next.seq         = snap_reg.seq + 32'd1;
                kind_next             = rfp_pkg::EV_ROBOT_STATUS;
                state_next            = rfp_pkg::ST_EMIT;
            end
            rfp_pkg::ST_E15:
            begin
                lo_next    = rd_byte;
                rd_off     = PW'(rfp_pkg::OFF_ENERGY + 1);
                state_next = rfp_pkg::ST_E16;
            end
            rfp_pkg::ST_E16:
            begin
                snap_next.energy = rd_word;
                snap_next.stamp  = stamp_tmp_reg;
                snap_next.seq    = snap_reg.seq + 32'd1;
                kind_next        = rfp_pkg::EV_POWER;
                state_next       = rfp_pkg::ST_EMIT;
            end
            rfp_pkg::ST_EMIT:
            begin
                if (!ev_stall)
                begin
                    ev_push    = 1'b1;
                    state_next = rfp_pkg::ST_DROP;
                end
            end
            rfp_pkg::ST_DROP:
            begin
                head_next = head_sum[PW-1:0];
                fill_next = fill_reg - drop_n_reg;
                if (dec_reg)
                begin
                    fs_next      = now_reg;
                    fs_head_next = 1'b0;
                end
                else
                begin
                    fs_head_next = 1'b1;
                end
                state_next = rfp_pkg::ST_START;
            end
            rfp_pkg::ST_FINISH:
            begin
                if (!ev_stall)
                begin
                    ev_flush = 1'b1;
                    if (tmo_reg)
                    begin
                        fs_next      = now_reg;
                        fs_head_next = 1'b0;
                        tmo_next     = 1'b0;
                    end
                    state_next = rfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfp_pkg::ST_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            drop_n_reg    <= '0;
            lo_reg        <= '0;
            word_reg      <= '0;
            robot_tmp_reg <= '0;
            cmd_reg       <= '0;
            stamp_tmp_reg <= '0;
            now_reg       <= '0;
            kind_reg      <= '0;
            ev_cmd_reg    <= '0;
            dec_reg       <= 1'b0;
            tmo_reg       <= 1'b0;
            fs_reg        <= '0;
            fs_head_reg   <= 1'b0;
            proto_ok_reg  <= 1'b1;
            timeout_reg   <= rfp_pkg::TIMEOUT_DEF;
            snap_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            drop_n_reg    <= drop_n_next;
            lo_reg        <= lo_next;
            word_reg      <= word_next;
            robot_tmp_reg <= robot_tmp_next;
            cmd_reg       <= cmd_next;
            stamp_tmp_reg <= stamp_tmp_next;
            now_reg       <= now_next;
            kind_reg      <= kind_next;
            ev_cmd_reg    <= ev_cmd_next;
            dec_reg       <= dec_next;
            tmo_reg       <= tmo_next;
            fs_reg        <= fs_next;
            fs_head_reg   <= fs_head_next;
            proto_ok_reg  <= proto_ok_next;
            timeout_reg   <= timeout_next;
            snap_reg      <= snap_next;
        end
    end

    assign event_res       = out_ev.kind;
    assign command_id      = (cmd_reg == out_ev.cmd) ? cmd_reg : out_ev.cmd;
    assign robot_id        = out_ev.snap.robot_id;
    assign gimbal_on       = out_ev.snap.flags[0];
    assign chassis_on      = out_ev.snap.flags[1];
    assign shooter_on      = out_ev.snap.flags[2];
    assign power_limit_w   = out_ev.snap.power_limit;
    assign buffer_energy_j = out_ev.snap.energy;
    assign stamp_ms        = out_ev.snap.stamp;
    assign message_seq     = out_ev.snap.seq;

endmodule

FILE: hdl/rfp_checker.sv
// Port-level checker for the referee frame parser, bound to the top level.
`include "referee_frame_parser_defines.svh"

module rfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [15:0] command_id,
    input logic [31:0] message_seq,
    input logic        last
);

    `RFP_ASSERT(a_busy_after_request, in_valid && in_ready |=> !in_ready, "ready right after a request")

    `RFP_ASSERT(a_hdr_event_no_cmd, out_valid && (event_res == rfp_pkg::EV_CRC8 || event_res == rfp_pkg::EV_CRC16 || event_res == rfp_pkg::EV_OVERSIZE || event_res == rfp_pkg::EV_TIMEOUT) |-> command_id == 16'h0000, "header event carries a command id")

    `RFP_ASSERT(a_status_cmd, out_valid && event_res == rfp_pkg::EV_ROBOT_STATUS |-> command_id == rfp_pkg::CMD_ROBOT_STATUS, "robot status event with wrong command")

    `RFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(message_seq) && $stable(last), "stalled result changed")

    `RFP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind referee_frame_parser rfp_checker u_rfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .command_id  (command_id),
    .message_seq (message_seq),
    .last        (last)
);
